// ===== rtl/core/lru_kv_pkg.sv =====
package lru_kv_pkg;

  // cache geometry
  localparam int MAX_SLOTS = 4;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int RANK_W    = SLOT_W;
  localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);

  // field widths
  localparam int KEY_W = 8;
  localparam int VAL_W = 32;
  localparam int CAP_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ===== rtl/core/lru_key_value_cache_top.sv =====
// Fully associative key-value cache, four entries, least-recently-used
// replacement.
// Input channel (in_valid / in_stall) carries one item: action (0 get,
// 1 put), an 8-bit key and a 32-bit signed value. Output channel
// (out_valid / out_stall) returns one item per input item: found and
// read_value (stored value on a get hit, zero otherwise).
// Capacity (1..4, 0 acts as 1, above 4 acts as 4) is written through
// cfg_write_en / cfg_write_data; the user is to write it only while
// the cache is idle, which the block itself does not enforce.
// An item is first captured, then the slot compare, recency update and
// result load happen together, and only after that is a new item taken.
// A waiting result in the output register does not hold off the next
// item; a new item waits in its capture register only until the output
// register is free.
// Reset (rst, synchronous) empties all slots, clears recency ranks and
// the fill count, and sets capacity to 4.
// While out_stall is high the result holds steady on the ports.
module lru_key_value_cache_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write_en,
  input  logic [lru_kv_pkg::CAP_W-1:0]           cfg_write_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   action,
  input  logic [lru_kv_pkg::KEY_W-1:0]           key,
  input  logic signed [lru_kv_pkg::VAL_W-1:0]    value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   found,
  output logic signed [lru_kv_pkg::VAL_W-1:0]    read_value
);
  import lru_kv_pkg::*;

  cmd_t cmd;

  // handshake control
  lru_kv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // slot storage and lookup
  lru_kv_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .action         (action),
    .key            (key),
    .value          (value),
    .found          (found),
    .read_value     (read_value)
  );

endmodule

// ===== rtl/core/lru_kv_ctrl.sv =====
module lru_kv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lru_kv_pkg::cmd_t  cmd
);
  import lru_kv_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  // result register can take a new item when empty or being drained
  assign out_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/lru_kv_dpath.sv =====
module lru_kv_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lru_kv_pkg::cmd_t                       cmd,
  input  logic                                   cfg_write_en,
  input  logic [lru_kv_pkg::CAP_W-1:0]           cfg_write_data,
  input  logic                                   action,
  input  logic [lru_kv_pkg::KEY_W-1:0]           key,
  input  logic signed [lru_kv_pkg::VAL_W-1:0]    value,
  output logic                                   found,
  output logic signed [lru_kv_pkg::VAL_W-1:0]    read_value
);
  import lru_kv_pkg::*;

  // captured item
  logic             action_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  // configuration
  logic [CAP_W-1:0] capacity;

  // slot state
  logic [MAX_SLOTS-1:0] slot_valid;
  logic [KEY_W-1:0]     slot_key     [MAX_SLOTS];
  logic [VAL_W-1:0]     slot_value   [MAX_SLOTS];
  logic [RANK_W-1:0]    slot_recency [MAX_SLOTS];
  logic [COUNT_W-1:0]   fill_count;

  logic [MAX_SLOTS-1:0] slot_valid_next;
  logic [KEY_W-1:0]     slot_key_next     [MAX_SLOTS];
  logic [VAL_W-1:0]     slot_value_next   [MAX_SLOTS];
  logic [RANK_W-1:0]    slot_recency_next [MAX_SLOTS];
  logic [COUNT_W-1:0]   fill_count_next;
  logic                 found_next;
  logic [VAL_W-1:0]     read_value_next;

  // lookup results
  logic                 hit_any;
  logic [SLOT_W-1:0]    hit_idx;
  logic                 free_any;
  logic [SLOT_W-1:0]    free_idx;
  logic                 old_any;
  logic [SLOT_W-1:0]    old_idx;
  logic [RANK_W-1:0]    old_rank;
  logic [COUNT_W-1:0]   cap_eff;
  logic                 evict;
  logic [SLOT_W-1:0]    ins_idx;
  logic [RANK_W-1:0]    hit_rank;
  logic [MAX_SLOTS-1:0] valid_tmp;
  logic [COUNT_W-1:0]   fill_tmp;

  // parallel compare, first free slot, least recent slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    old_any  = 1'b0;
    old_idx  = '0;
    old_rank = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (slot_valid[i] && slot_key[i] == key_q && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!slot_valid[i] && !free_any) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
      if (slot_valid[i] && (!old_any || slot_recency[i] > old_rank)) begin
        old_any  = 1'b1;
        old_idx  = SLOT_W'(i);
        old_rank = slot_recency[i];
      end
    end
  end

  // effective capacity, clamped to one..max slots
  always_comb begin
    if (capacity == '0) begin
      cap_eff = COUNT_W'(1);
    end else if (COUNT_W'(capacity) > COUNT_W'(MAX_SLOTS)) begin
      cap_eff = COUNT_W'(MAX_SLOTS);
    end else begin
      cap_eff = COUNT_W'(capacity);
    end
  end

  assign evict    = (fill_count >= cap_eff) || !free_any;
  assign ins_idx  = evict ? old_idx : free_idx;
  assign hit_rank = slot_recency[hit_idx];

  // update of the slot state for one item
  always_comb begin
    slot_valid_next   = slot_valid;
    slot_key_next     = slot_key;
    slot_value_next   = slot_value;
    slot_recency_next = slot_recency;
    fill_count_next   = fill_count;
    found_next        = 1'b0;
    read_value_next   = '0;
    valid_tmp         = slot_valid;
    fill_tmp          = fill_count;
    if (hit_any) begin
      // hit: read or overwrite, then promote
      found_next = 1'b1;
      if (action_q == ACT_GET) begin
        read_value_next = slot_value[hit_idx];
      end else begin
        slot_value_next[hit_idx] = value_q;
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (slot_valid[i] && SLOT_W'(i) != hit_idx && slot_recency[i] < hit_rank) begin
          slot_recency_next[i] = slot_recency[i] + RANK_W'(1);
        end
      end
      slot_recency_next[hit_idx] = '0;
    end else if (action_q == ACT_PUT) begin
      // miss on put: evict if needed, age the rest, insert as most recent
      if (evict) begin
        valid_tmp[ins_idx] = 1'b0;
        if (fill_count != '0) begin
          fill_tmp = fill_count - COUNT_W'(1);
        end
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (valid_tmp[i]) begin
          slot_recency_next[i] = slot_recency[i] + RANK_W'(1);
        end
      end
      slot_valid_next             = valid_tmp;
      slot_valid_next[ins_idx]    = 1'b1;
      slot_key_next[ins_idx]      = key_q;
      slot_value_next[ins_idx]    = value_q;
      slot_recency_next[ins_idx]  = '0;
      fill_count_next             = fill_tmp + COUNT_W'(1);
    end
  end

  // control state of the cache
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      fill_count <= '0;
      capacity   <= CAP_RESET;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_recency[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (cmd.exec) begin
        slot_valid   <= slot_valid_next;
        fill_count   <= fill_count_next;
        slot_recency <= slot_recency_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
      key_q    <= key;
      value_q  <= value;
    end
    if (cmd.exec) begin
      slot_key   <= slot_key_next;
      slot_value <= slot_value_next;
      found      <= found_next;
      read_value <= read_value_next;
    end
  end

endmodule
